// ===== rtl/gaussian_blur_3x3_stream_core_macros.svh =====
// ----------------------------------------------------------------------------
// gaussian blur stream core assertion macros
// shared assertion forms for the checker, clocked on clock, reset high
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_STREAM_CORE_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define GB3_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define GB3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// holds in the cycle after reset is seen
`define GB3_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gb3_pkg.sv =====
// ----------------------------------------------------------------------------
// gb3_pkg
// types and fixed constants of the 3x3 gaussian blur stream core
// ----------------------------------------------------------------------------
package gb3_pkg;

   // one rgb pixel, red in the upper byte
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // one column of the 3x3 neighborhood, oldest row first
   typedef struct packed {
      pixel_type row_two;
      pixel_type row_one;
      pixel_type row_cur;
   } column_type;

   // request kinds
   localparam logic REQ_FLUSH = 1'b1;

   // register map, index is paddr[2]
   localparam int  PADDR_W         = 3;
   localparam int  PDATA_W         = 32;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam int MIN_DIM = 3;

   // kernel weights sum to 16
   localparam int KERNEL_SHIFT = 4;

endpackage

// ===== rtl/gaussian_blur_3x3_stream_core.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_core
// 3x3 gaussian blur over a raster rgb stream, border pixels passed through
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/stall    | req_type, req_in_red/green/blue
//   rsp     | out       | rsp_valid/stall    | rsp_out_red/green/blue, frame_last
//   csr     | in/out    | apb-style, pready=1| image_width @0, image_height @4
//
// one transfer per clock on req unless stalled; results pass the second stage and
// output registers. the row-end pixel of each row but the first releases two
// results, one per unstalled cycle through the single output register, and
// stalls req while both are owed. reset clears counters, window and handshake
// state at once; the two line stores are not cleared and need no clearing pass.
// a stalled rsp holds its payload and backs up into req within the same cycle.
//
module gaussian_blur_3x3_stream_core import gb3_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [7:0]         req_in_red,
   input  logic [7:0]         req_in_green,
   input  logic [7:0]         req_in_blue,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   output logic               rsp_frame_last,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   // frame size
   logic [CW-1:0] width_last;
   logic [RW-1:0] height_last;

   // position counters, owned by the accept stage
   logic [CW-1:0] col_count_ff, col_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] flush_count_ff, flush_count_in;
   logic          draining_ff, draining_in;

   // accept stage decode
   logic          accept;
   logic          take_pixel;
   logic          take_flush;
   logic          row_end;
   logic          frame_end;
   logic          flush_done;
   pixel_type     in_pixel;

   // line store ports
   logic          above_rd_en;
   logic [CW-1:0] above_rd_addr;
   pixel_type     above_rd_data;
   pixel_type     two_rd_data;
   logic          two_wr_en;

   // second stage: line data arrives, results go out one per cycle unless stalled
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_pixel_ff, s1_pixel_in;
   logic          s1_need_a_ff, s1_need_a_in;
   logic          s1_need_b_ff, s1_need_b_in;
   logic          s1_border_ff, s1_border_in;
   logic          s1_last_ff, s1_last_in;
   pixel_type     s1_pix_ff, s1_pix_in;
   logic [CW-1:0] s1_addr_ff, s1_addr_in;
   logic          s1_leave;
   logic          emit_a;
   logic          emit_b;

   // two previous columns of the neighborhood, index 0 is the older
   column_type    win_ff [2];
   column_type    cur_col;
   pixel_type     blur;
   pixel_type     result_a;

   // output register
   logic          out_free;
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_pix_ff, rsp_pix_in;
   logic          rsp_last_ff, rsp_last_in;

   gb3_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .width_last  (width_last),
      .height_last (height_last)
   );

   // ---------------------------------------------------------------------
   // accept stage
   // ---------------------------------------------------------------------

   // a new item enters only when the second stage is empty or draining now
   assign req_stall = s1_valid_ff & ~s1_leave;
   assign accept    = req_valid & ~req_stall;

   // a pixel while draining and a flush outside draining are dropped
   assign take_flush = accept & (req_type == REQ_FLUSH) & draining_ff;
   assign take_pixel = accept & (req_type != REQ_FLUSH) & ~draining_ff;

   assign row_end    = col_count_ff >= width_last;
   assign frame_end  = row_count_ff >= height_last;
   assign flush_done = flush_count_ff >= width_last;

   assign in_pixel = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   always_comb begin
      col_count_in   = col_count_ff;
      row_count_in   = row_count_ff;
      flush_count_in = flush_count_ff;
      draining_in    = draining_ff;
      if (take_flush) begin
         if (flush_done) begin
            // last pixel of the frame is out, start over
            draining_in    = 1'b0;
            flush_count_in = '0;
            row_count_in   = '0;
            col_count_in   = '0;
         end else begin
            flush_count_in = flush_count_ff + 1'b1;
         end
      end else if (take_pixel) begin
         if (row_end) begin
            col_count_in = '0;
            if (frame_end) begin
               // last row stays in the line store until flushed
               draining_in    = 1'b1;
               flush_count_in = '0;
               row_count_in   = '0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
            end
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         flush_count_ff <= '0;
         draining_ff    <= 1'b0;
      end else begin
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         flush_count_ff <= flush_count_in;
         draining_ff    <= draining_in;
      end
   end

   // ---------------------------------------------------------------------
   // line stores
   // ---------------------------------------------------------------------

   // the row above: read and overwritten with the new pixel in the same cycle,
   // the old entry comes back; flushes read it along the last row
   assign above_rd_en   = take_pixel | take_flush;
   assign above_rd_addr = take_flush ? flush_count_ff : col_count_ff;

   gb3_line_ram #(
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .rd_en   (above_rd_en),
      .rd_addr (above_rd_addr),
      .rd_data (above_rd_data),
      .wr_en   (take_pixel),
      .wr_addr (col_count_ff),
      .wr_data (in_pixel)
   );

   // the row two above: takes the old row-above entry once it has been read,
   // when the pixel leaves the second stage. the read in the accept stage is
   // always at the next column, so the two never meet on one entry
   assign two_wr_en = s1_leave & s1_pixel_ff;

   gb3_line_ram #(
      .DEPTH (MAX_WIDTH)
   ) u_line_two_above (
      .clock   (clock),
      .rd_en   (take_pixel),
      .rd_addr (col_count_ff),
      .rd_data (two_rd_data),
      .wr_en   (two_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (above_rd_data)
   );

   // ---------------------------------------------------------------------
   // second stage
   // ---------------------------------------------------------------------

   // result a is the window center, result b the row-above entry (last
   // column on a row end, or the flushed last-row pixel); a goes first
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign emit_a   = s1_valid_ff & s1_need_a_ff & out_free;
   assign emit_b   = s1_valid_ff & ~s1_need_a_ff & s1_need_b_ff & out_free;
   assign s1_leave = s1_valid_ff & ((~s1_need_a_ff & ~s1_need_b_ff) |
                                    (out_free & ~(s1_need_a_ff & s1_need_b_ff)));

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pixel_in  = s1_pixel_ff;
      s1_need_a_in = s1_need_a_ff & ~emit_a;
      s1_need_b_in = s1_need_b_ff & ~emit_b;
      s1_border_in = s1_border_ff;
      s1_last_in   = s1_last_ff;
      s1_pix_in    = s1_pix_ff;
      s1_addr_in   = s1_addr_ff;
      if (accept) begin
         s1_valid_in  = take_pixel | take_flush;
         s1_pixel_in  = take_pixel;
         s1_need_a_in = take_pixel & (row_count_ff != '0) & (col_count_ff != '0);
         s1_need_b_in = take_flush | (take_pixel & (row_count_ff != '0) & row_end);
         // second row or second column: center pixel passes through
         s1_border_in = (row_count_ff == RW'(1)) | (col_count_ff == CW'(1));
         s1_last_in   = take_flush & flush_done;
         s1_pix_in    = in_pixel;
         s1_addr_in   = col_count_ff;
      end else if (s1_leave) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_pixel_ff  <= 1'b0;
         s1_need_a_ff <= 1'b0;
         s1_need_b_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_pixel_ff  <= s1_pixel_in;
         s1_need_a_ff <= s1_need_a_in;
         s1_need_b_ff <= s1_need_b_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_border_ff <= s1_border_in;
      s1_last_ff   <= s1_last_in;
      s1_pix_ff    <= s1_pix_in;
      s1_addr_ff   <= s1_addr_in;
   end

   // current column as read from the line stores plus the new pixel
   assign cur_col = '{row_two: two_rd_data, row_one: above_rd_data, row_cur: s1_pix_ff};

   gb3_kernel u_kernel (
      .left_col  (win_ff[0]),
      .mid_col   (win_ff[1]),
      .right_col (cur_col),
      .blur      (blur)
   );

   assign result_a = s1_border_ff ? win_ff[1].row_one : blur;

   // window shifts once per pixel, after its results are out
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
      end else if (s1_leave & s1_pixel_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= cur_col;
      end
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit_a | emit_b;
      end
      if (emit_a) begin
         rsp_pix_in  = result_a;
         rsp_last_in = 1'b0;
      end else if (emit_b) begin
         rsp_pix_in  = above_rd_data;
         rsp_last_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff.red;
   assign rsp_out_green  = rsp_pix_ff.green;
   assign rsp_out_blue   = rsp_pix_ff.blue;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ===== rtl/gb3_line_ram.sv =====
// ----------------------------------------------------------------------------
// gb3_line_ram
// one line store: single write port, one registered read port, read-first
// ----------------------------------------------------------------------------
module gb3_line_ram import gb3_pkg::*; #(
   parameter  int DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output pixel_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pixel_type     wr_data
);

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   // read returns the old entry when the same address is written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gb3_kernel.sv =====
// ----------------------------------------------------------------------------
// gb3_kernel
// 1-2-1 by 1-2-1 weighted sum over a 3x3 window, divided by 16, per channel
// ----------------------------------------------------------------------------
module gb3_kernel import gb3_pkg::*; (
   input  column_type left_col,
   input  column_type mid_col,
   input  column_type right_col,
   output pixel_type  blur
);

   function automatic logic [9:0] col_weight(input logic [7:0] top,
                                             input logic [7:0] mid,
                                             input logic [7:0] bot);
      col_weight = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, bot};
   endfunction

   function automatic logic [7:0] kernel_out(input logic [9:0] l,
                                             input logic [9:0] m,
                                             input logic [9:0] r);
      logic [11:0] total;
      total      = {2'b00, l} + {1'b0, m, 1'b0} + {2'b00, r};
      kernel_out = 8'(total >> KERNEL_SHIFT);
   endfunction

   always_comb begin
      blur.red = kernel_out(
         col_weight(left_col.row_two.red, left_col.row_one.red, left_col.row_cur.red),
         col_weight(mid_col.row_two.red, mid_col.row_one.red, mid_col.row_cur.red),
         col_weight(right_col.row_two.red, right_col.row_one.red, right_col.row_cur.red));
      blur.green = kernel_out(
         col_weight(left_col.row_two.green, left_col.row_one.green,
                    left_col.row_cur.green),
         col_weight(mid_col.row_two.green, mid_col.row_one.green, mid_col.row_cur.green),
         col_weight(right_col.row_two.green, right_col.row_one.green,
                    right_col.row_cur.green));
      blur.blue = kernel_out(
         col_weight(left_col.row_two.blue, left_col.row_one.blue, left_col.row_cur.blue),
         col_weight(mid_col.row_two.blue, mid_col.row_one.blue, mid_col.row_cur.blue),
         col_weight(right_col.row_two.blue, right_col.row_one.blue,
                    right_col.row_cur.blue));
   end

endmodule

// ===== rtl/gb3_csr.sv =====
// ----------------------------------------------------------------------------
// gb3_csr
// frame size registers on an apb-style port, clamped last column and row
// ----------------------------------------------------------------------------
module gb3_csr import gb3_pkg::*; #(
   parameter  int MAX_WIDTH  = 1024,
   parameter  int MAX_HEIGHT = 4096,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output logic [CW-1:0]      width_last,
   output logic [RW-1:0]      height_last
);

   localparam int WCMP = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;
   localparam int HCMP = (RW + 1 > HEIGHT_BITS) ? RW + 1 : HEIGHT_BITS;

   logic [WIDTH_BITS-1:0]  image_width_ff, image_width_in;
   logic [HEIGHT_BITS-1:0] image_height_ff, image_height_in;
   logic                   reg_index;
   logic                   wr_transfer;
   logic [WCMP-1:0]        width_ext;
   logic [HCMP-1:0]        height_ext;

   assign pready      = 1'b1;
   assign reg_index   = paddr[2];
   assign wr_transfer = psel & penable & pwrite & pready;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (wr_transfer) begin
         case (reg_index)
            REG_IMAGE_WIDTH:  image_width_in  = pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_in = pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp to [3, max] and hand out size minus one
   assign width_ext  = WCMP'(image_width_ff);
   assign height_ext = HCMP'(image_height_ff);

   always_comb begin
      if (width_ext < WCMP'(MIN_DIM)) begin
         width_last = CW'(MIN_DIM - 1);
      end else if (width_ext > WCMP'(MAX_WIDTH)) begin
         width_last = CW'(MAX_WIDTH - 1);
      end else begin
         width_last = CW'(width_ext - WCMP'(1));
      end
      if (height_ext < HCMP'(MIN_DIM)) begin
         height_last = RW'(MIN_DIM - 1);
      end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
         height_last = RW'(MAX_HEIGHT - 1);
      end else begin
         height_last = RW'(height_ext - HCMP'(1));
      end
   end

endmodule

// ===== rtl/gb3_checker.sv =====
// ----------------------------------------------------------------------------
// gb3_checker
// port-level checks of the gaussian blur stream core, bound to the top level
// ----------------------------------------------------------------------------
`include "gaussian_blur_3x3_stream_core_macros.svh"

module gb3_checker import gb3_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_out_red,
   input logic [7:0]         rsp_out_green,
   input logic [7:0]         rsp_out_blue,
   input logic               rsp_frame_last
);

   // a stalled result stays offered
   `GB3_ASSERT_NEXT(a_rsp_valid_held, rsp_valid && rsp_stall, rsp_valid,
      "rsp_valid dropped while stalled")

   // a stalled result keeps its payload
   `GB3_ASSERT_NEXT(a_rsp_payload_held, rsp_valid && rsp_stall,
      $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue)
         && $stable(rsp_frame_last),
      "rsp payload changed while stalled")

   // an empty output register is filled only by a req transfer, via the second stage
   `GB3_ASSERT_NOW(a_rsp_from_transfer, $rose(rsp_valid),
      $past(req_valid && !req_stall, 2),
      "result appeared without a req transfer two cycles before")

   // nothing is offered right after reset
   `GB3_ASSERT_RESET(a_rsp_idle_after_reset, !rsp_valid, "rsp_valid high after reset")

endmodule

bind gaussian_blur_3x3_stream_core gb3_checker u_gb3_checker (.*);

// ===== tb/sv/gaussian_blur_3x3_stream_checker.sv =====
// ----------------------------------------------------------------------------
// gaussian blur stream checker
// watches the req, rsp and csr ports, keeps its own copy of the line stores,
// window and counters, predicts every blurred pixel and compares field by field
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_checker import gb3_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_type,
   input  logic [7:0]         req_in_red,
   input  logic [7:0]         req_in_green,
   input  logic [7:0]         req_in_blue,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [7:0]         rsp_out_red,
   input  logic [7:0]         rsp_out_green,
   input  logic [7:0]         rsp_out_blue,
   input  logic               rsp_frame_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   input  logic [PDATA_W-1:0] csr_prdata,
   input  logic               csr_pready,
   output int                 mismatch_count,
   output int                 results_owed
);

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } owed_pixel_type;

   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   pixel_type              row_above [MAX_WIDTH];
   pixel_type              row_two_above [MAX_WIDTH];
   column_type             win_left;
   column_type             win_mid;
   logic [11:0]            row_idx;
   logic [9:0]             col_idx;
   logic [10:0]            flush_idx;
   logic                   draining;
   owed_pixel_type         owed_pixels [$];
   owed_pixel_type         oldest;
   logic [PDATA_W-1:0]     csr_readback;

   function automatic int clamp_dim(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // 1-2-1 weighted column of one channel
   function automatic int column_taps(column_type col, int sh);
      return int'((col.row_two >> sh) & 24'hFF) + 2 * int'((col.row_one >> sh) & 24'hFF)
         + int'((col.row_cur >> sh) & 24'hFF);
   endfunction

   function automatic pixel_type blur_window(column_type l, column_type m, column_type r);
      pixel_type p;
      p.red   = 8'((column_taps(l, 16) + 2 * column_taps(m, 16) + column_taps(r, 16))
                   >> KERNEL_SHIFT);
      p.green = 8'((column_taps(l, 8) + 2 * column_taps(m, 8) + column_taps(r, 8))
                   >> KERNEL_SHIFT);
      p.blue  = 8'((column_taps(l, 0) + 2 * column_taps(m, 0) + column_taps(r, 0))
                   >> KERNEL_SHIFT);
      return p;
   endfunction

   // one accepted request moves the raster position and may owe results
   task automatic advance_raster(input logic kind, input pixel_type px);
      int         w;
      int         h;
      int         c;
      logic       row_end;
      logic       last;
      column_type fresh;
      w = clamp_dim(int'(width_reg), MIN_DIM, MAX_WIDTH);
      h = clamp_dim(int'(height_reg), MIN_DIM, MAX_HEIGHT);
      if (kind == REQ_FLUSH) begin
         if (!draining) return;
         c = int'(flush_idx) < MAX_WIDTH ? int'(flush_idx) : MAX_WIDTH - 1;
         last = int'(flush_idx) >= w - 1;
         owed_pixels.push_back('{pix: row_above[c], last: last});
         if (last) begin
            draining  = 1'b0;
            flush_idx = '0;
            row_idx   = '0;
            col_idx   = '0;
         end else begin
            flush_idx++;
         end
         return;
      end
      if (draining) return;
      c = int'(col_idx) < MAX_WIDTH ? int'(col_idx) : MAX_WIDTH - 1;
      fresh.row_two = row_two_above[c];
      fresh.row_one = row_above[c];
      fresh.row_cur = px;
      row_end = int'(col_idx) >= w - 1;
      row_two_above[c] = fresh.row_one;
      row_above[c]     = px;
      if (row_idx >= 1 && col_idx >= 1) begin
         if (row_idx == 1 || col_idx == 1)
            owed_pixels.push_back('{pix: win_mid.row_one, last: 1'b0});
         else
            owed_pixels.push_back('{pix: blur_window(win_left, win_mid, fresh), last: 1'b0});
      end
      if (row_idx >= 1 && row_end)
         owed_pixels.push_back('{pix: fresh.row_one, last: 1'b0});
      win_left = win_mid;
      win_mid  = fresh;
      if (row_end) begin
         col_idx = '0;
         if (int'(row_idx) >= h - 1) begin
            draining  = 1'b1;
            flush_idx = '0;
            row_idx   = '0;
         end else begin
            row_idx++;
         end
      end else begin
         col_idx++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         win_left  = '0;
         win_mid   = '0;
         row_idx   = '0;
         col_idx   = '0;
         flush_idx = '0;
         draining  = 1'b0;
         owed_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_IMAGE_WIDTH) width_reg = csr_pwdata[WIDTH_BITS-1:0];
               else height_reg = csr_pwdata[HEIGHT_BITS-1:0];
            end else begin
               csr_readback = (csr_paddr[2] == REG_IMAGE_WIDTH) ? PDATA_W'(width_reg)
                                                                : PDATA_W'(height_reg);
               if (csr_prdata !== csr_readback) begin
                  $error("csr_prdata: expected %0d, got %0d", csr_readback, csr_prdata);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            advance_raster(req_type, '{red: req_in_red, green: req_in_green,
                                       blue: req_in_blue});
         if (rsp_valid && !rsp_stall) begin
            if (owed_pixels.size() == 0) begin
               $error("rsp transfer with no result expected");
               mismatch_count++;
            end else begin
               oldest = owed_pixels.pop_front();
               if (rsp_out_red !== oldest.pix.red) begin
                  $error("out_red: expected %0d, got %0d", oldest.pix.red, rsp_out_red);
                  mismatch_count++;
               end
               if (rsp_out_green !== oldest.pix.green) begin
                  $error("out_green: expected %0d, got %0d", oldest.pix.green, rsp_out_green);
                  mismatch_count++;
               end
               if (rsp_out_blue !== oldest.pix.blue) begin
                  $error("out_blue: expected %0d, got %0d", oldest.pix.blue, rsp_out_blue);
                  mismatch_count++;
               end
               if (rsp_frame_last !== oldest.last) begin
                  $error("frame_last: expected %0d, got %0d", oldest.last, rsp_frame_last);
                  mismatch_count++;
               end
            end
         end
      end
      results_owed = owed_pixels.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives raster frames with flush tails into the gaussian blur core through
// random idle and stall, reprograms the frame size between and inside frames,
// and leaves prediction and comparison to the checker beside the core
// ----------------------------------------------------------------------------
module tb_top;
   import gb3_pkg::*;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int RANDOM_ITEMS   = 1620;
   localparam int IDLE_PERCENT   = 21;
   localparam int NOISE_PERCENT  = 3;
   // results pass the second stage and output registers, leave margin
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   // widest frame the random part uses, also the width of the priming rows
   localparam int PRIME_WIDTH    = 48;
   localparam logic REQ_PIXEL = ~REQ_FLUSH;
   localparam logic [PADDR_W-1:0] WIDTH_ADDR  = PADDR_W'({REG_IMAGE_WIDTH, 2'b00});
   localparam logic [PADDR_W-1:0] HEIGHT_ADDR = PADDR_W'({REG_IMAGE_HEIGHT, 2'b00});

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_type;
   logic [7:0]         req_in_red;
   logic [7:0]         req_in_green;
   logic [7:0]         req_in_blue;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_out_red;
   logic [7:0]         rsp_out_green;
   logic [7:0]         rsp_out_blue;
   logic               rsp_frame_last;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [PADDR_W-1:0] csr_paddr;
   logic [PDATA_W-1:0] csr_pwdata;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;
   int                 mismatch_count;
   int                 results_owed;
   // no idling on either side while set
   logic               calm = 1'b0;
   int                 stuck_cycles = 0;
   int                 items_done;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   gaussian_blur_3x3_stream_core #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   gaussian_blur_3x3_stream_checker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // receiver backpressure, changed at the falling edge only
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   // cycles since the last transfer on any port
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   function automatic int clamp_dim(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic bit skip_cycle();
      return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   // mostly random, with some black and white pixels to hit the sum extremes
   function automatic pixel_type random_pixel();
      pixel_type p;
      case ($urandom_range(0, 9))
         0: begin
            p = '0;
         end
         1: begin
            p = '1;
         end
         default: begin
            p = 24'($urandom);
         end
      endcase
      return p;
   endfunction

   // one req transfer, entered and left at a falling edge
   task automatic push_item(input logic kind, input pixel_type px);
      while (skip_cycle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_in_red   <= px.red;
      req_in_green <= px.green;
      req_in_blue  <= px.blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // setup then access phase, then idle with psel low
   task automatic csr_access(input logic write, input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // write both size registers, then read them back for the checker
   task automatic program_size(input logic [WIDTH_BITS-1:0] w_reg,
                               input logic [HEIGHT_BITS-1:0] h_reg);
      csr_access(1'b1, WIDTH_ADDR, PDATA_W'(w_reg));
      csr_access(1'b1, HEIGHT_ADDR, PDATA_W'(h_reg));
      csr_access(1'b0, WIDTH_ADDR, '0);
      csr_access(1'b0, HEIGHT_ADDR, '0);
   endtask

   // all owed results in, then the SETTLE_CYCLES margin for work that owes nothing
   task automatic settle();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one frame of random pixels plus its flush tail; at pixel index split the
   // size is reprogrammed mid-frame, and the remaining pixel count follows the
   // core's >= compares against the new size
   task automatic send_frame(input logic [WIDTH_BITS-1:0] w_reg,
                             input logic [HEIGHT_BITS-1:0] h_reg, input int split,
                             input logic [WIDTH_BITS-1:0] w_alt,
                             input logic [HEIGHT_BITS-1:0] h_alt);
      int w;
      int h;
      int total;
      int sent;
      int r;
      int k;
      settle();
      program_size(w_reg, h_reg);
      w = clamp_dim(int'(w_reg), MIN_DIM, MAX_WIDTH);
      h = clamp_dim(int'(h_reg), MIN_DIM, MAX_HEIGHT);
      total = w * h;
      sent = 0;
      while (sent < total) begin
         if (sent == split) begin
            settle();
            program_size(w_alt, h_alt);
            r = sent / w;
            k = sent % w;
            w = clamp_dim(int'(w_alt), MIN_DIM, MAX_WIDTH);
            h = clamp_dim(int'(h_alt), MIN_DIM, MAX_HEIGHT);
            total = sent + ((k >= w - 1) ? 1 : w - k) + ((r < h - 1) ? (h - 1 - r) * w : 0);
         end
         // stray flush before the frame is complete, ignored by the core
         if ($urandom_range(0, 99) < NOISE_PERCENT) push_item(REQ_FLUSH, random_pixel());
         push_item(REQ_PIXEL, random_pixel());
         sent++;
      end
      for (int i = 0; i < w; i++) begin
         // stray pixel while the last row drains, ignored by the core
         if ($urandom_range(0, 99) < NOISE_PERCENT) push_item(REQ_PIXEL, random_pixel());
         push_item(REQ_FLUSH, random_pixel());
      end
      items_done += sent + w;
   endtask

   initial begin
      pixel_type              stripe;
      int                     frame_no;
      int                     split;
      logic [WIDTH_BITS-1:0]  w_pick;
      logic [WIDTH_BITS-1:0]  w_alt;
      logic [HEIGHT_BITS-1:0] h_pick;
      logic [HEIGHT_BITS-1:0] h_alt;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = REQ_PIXEL;
      req_in_red   = '0;
      req_in_green = '0;
      req_in_blue  = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest frame: red saturated, green zero, blue a checkerboard
      program_size(WIDTH_BITS'(MIN_DIM), HEIGHT_BITS'(MIN_DIM));
      // flush while nothing is draining
      push_item(REQ_FLUSH, '1);
      for (int i = 0; i < MIN_DIM * MIN_DIM; i++) begin
         stripe.red   = 8'hFF;
         stripe.green = 8'h00;
         stripe.blue  = (i % 2) ? 8'hFF : 8'h00;
         push_item(REQ_PIXEL, stripe);
      end
      // pixel while the last row drains
      push_item(REQ_PIXEL, '1);
      for (int i = 0; i < MIN_DIM; i++) push_item(REQ_FLUSH, '0);

      // width register above the limit, cut mid-row to the widest random width;
      // its rows define every line store entry that later mid-frame width
      // growth can read
      send_frame('1, HEIGHT_BITS'(MIN_DIM), PRIME_WIDTH + 12, WIDTH_BITS'(PRIME_WIDTH),
                 HEIGHT_BITS'(MIN_DIM));
      // tallest setting cut short mid-frame by a height below the minimum
      send_frame(WIDTH_BITS'(1), '1, 10, WIDTH_BITS'(2), '0);

      items_done = 0;
      frame_no = 0;
      while (items_done < RANDOM_ITEMS) begin
         calm <= (frame_no >= 6 && frame_no < 10);
         case ($urandom_range(0, 9))
            0: w_pick = WIDTH_BITS'($urandom_range(0, 2));
            1: w_pick = WIDTH_BITS'($urandom_range(13, PRIME_WIDTH));
            default: w_pick = WIDTH_BITS'($urandom_range(3, 12));
         endcase
         case ($urandom_range(0, 9))
            0: h_pick = HEIGHT_BITS'($urandom_range(0, 2));
            1: h_pick = HEIGHT_BITS'($urandom_range(7, 12));
            default: h_pick = HEIGHT_BITS'($urandom_range(3, 6));
         endcase
         split = -1;
         w_alt = '0;
         h_alt = '0;
         if ($urandom_range(0, 3) == 0) begin
            split = $urandom_range(0, clamp_dim(int'(w_pick), MIN_DIM, MAX_WIDTH)
                                      * clamp_dim(int'(h_pick), MIN_DIM, MAX_HEIGHT) - 1);
            w_alt = WIDTH_BITS'($urandom_range(0, 20));
            h_alt = HEIGHT_BITS'($urandom_range(0, 8));
         end
         send_frame(w_pick, h_pick, split, w_alt, h_alt);
         frame_no++;
      end

      calm <= 1'b0;
      settle();
      if (mismatch_count == 0 && results_owed == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
